[rtl/core/usrzi_pkg.sv]
// Package with shared constants, codes and types of the ultrasonic ranger zone indicator.
package usrzi_pkg;

   // Echo width counter, saturating at its all-ones value
   localparam int PulseBits = 24;
   localparam int DistBits  = 16;
   localparam int ScaleBits = 32;
   localparam int DivBits   = 8;
   localparam int MicroBits = 20;
   localparam int TrigBits  = 10;
   localparam int GapBits   = 10;
   localparam int CsrIdxBits  = 3;
   localparam int CsrDataBits = 32;

   localparam logic [MicroBits-1:0] UsPerMs = MicroBits'(1000);

   // Register reset values
   localparam logic [DivBits-1:0]   TicksPerUsReset = DivBits'(16);
   localparam logic [TrigBits-1:0]  TriggerUsReset  = TrigBits'(12);
   localparam logic [MicroBits-1:0] GapUsReset      = MicroBits'(10000);
   localparam logic [ScaleBits-1:0] ScaleReset      = ScaleBits'(1578937);
   localparam logic [DistBits-1:0]  RedMaxReset     = DistBits'(6);
   localparam logic [DistBits-1:0]  BlueMaxReset    = DistBits'(12);
   localparam logic [DistBits-1:0]  GreenMaxReset   = DistBits'(24);

   localparam logic [PulseBits-1:0] PulseMax = {PulseBits{1'b1}};
   localparam logic [DistBits-1:0]  DistMax  = {DistBits{1'b1}};

   // Register indexes of the csr port
   typedef enum logic [CsrIdxBits-1:0] {
      CSR_TICKS_PER_US = 3'd0,
      CSR_TRIGGER_US   = 3'd1,
      CSR_GAP_MS       = 3'd2,
      CSR_SCALE        = 3'd3,
      CSR_RED_MAX      = 3'd4,
      CSR_BLUE_MAX     = 3'd5,
      CSR_GREEN_MAX    = 3'd6
   } csr_index_type;

   // Measurement cycle phases, one-hot
   typedef enum logic [4:0] {
      PH_TRIG_LOW  = 5'b00001,
      PH_TRIG_HIGH = 5'b00010,
      PH_WAIT      = 5'b00100,
      PH_COUNT     = 5'b01000,
      PH_GAP       = 5'b10000
   } phase_type;

   // Beat after the phase update
   typedef struct packed {
      logic                 vld;
      logic                 trig;
      logic                 cap;
      logic [PulseBits-1:0] ticks;
   } sample_stage_type;

   // Beat after the scaling multiply
   typedef struct packed {
      logic                 vld;
      logic                 trig;
      logic                 cap;
      logic [PulseBits-1:0] dist_raw;
   } scale_stage_type;

endpackage

[rtl/core/usrzi_req_if.sv]
// Request channel: one echo line sample per beat.
interface usrzi_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface

[rtl/core/usrzi_rsp_if.sv]
// Response channel: trigger level, zone indicators and distance per beat.
interface usrzi_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           trigger_out;
   logic                           red_on;
   logic                           blue_on;
   logic                           green_on;
   logic [usrzi_pkg::DistBits-1:0] distance;
   logic                           distance_valid;

   modport source (output valid, output trigger_out, output red_on, output blue_on,
                   output green_on, output distance, output distance_valid, input ready);
   modport sink   (input valid, input trigger_out, input red_on, input blue_on,
                   input green_on, input distance, input distance_valid, output ready);
endinterface

[rtl/core/ultrasonic_ranger_zone_indicator.sv]
// Top level of the ultrasonic ranger zone indicator: echo timing, scaling and zones.
//
// Usage:
//   req_ch carries one echo line sample per beat; each accepted beat is one tick
//   of the measurement cycle (trigger low, trigger high, wait for echo edge,
//   count echo width, gap). rsp_ch returns exactly one beat per request beat,
//   in order: trigger level, zone indicators and last distance after that tick;
//   distance_valid marks the beat on which a new distance was measured.
//   The csr port writes ticks_per_us, trigger_us, gap_ms, scale and the three
//   zone limits; write only while no beat is in flight.
// Pipeline: an accepted request beat passes the phase update, scaling multiply,
//   zone compare and output register on its way to the response.
// Throughput: one beat per cycle while not stalled; the 24 x 32 bit scaling multiply
//   sits alone in its own stage.
// Reset (synchronous, active high): registers return to their default values,
//   the cycle restarts in trigger low with indicators off and distance zero.
// Stall: while a response is held with rsp_ch.ready low, the whole pipeline
//   holds and req_ch.ready is low; no beat is lost or repeated.
module ultrasonic_ranger_zone_indicator (
   input  logic                              clock,
   input  logic                              reset,
   usrzi_req_if.sink                         req_ch,
   usrzi_rsp_if.source                       rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [usrzi_pkg::CsrIdxBits-1:0]  csr_index,
   input  logic [usrzi_pkg::CsrDataBits-1:0] csr_wr_data
);

   localparam int PB = usrzi_pkg::PulseBits;
   localparam int DB = usrzi_pkg::DistBits;
   localparam int SB = usrzi_pkg::ScaleBits;
   localparam int VB = usrzi_pkg::DivBits;
   localparam int MB = usrzi_pkg::MicroBits;
   localparam int TB = usrzi_pkg::TrigBits;
   localparam int GB = usrzi_pkg::GapBits;

   // Config registers
   logic [VB-1:0] ticks_per_us_ff;
   logic [TB-1:0] trigger_us_ff;
   logic [MB-1:0] gap_us_ff;
   logic [SB-1:0] scale_ff;
   logic [DB-1:0] red_max_ff, blue_max_ff, green_max_ff;

   // Cycle state
   usrzi_pkg::phase_type phase_ff, phase_in;
   logic [VB-1:0] tick_div_ff, tick_div_in;
   logic [MB-1:0] micro_count_ff, micro_count_in;
   logic [PB-1:0] pulse_ticks_ff, pulse_ticks_in;
   logic          echo_prev_ff;

   // Pipeline
   usrzi_pkg::sample_stage_type samp_ff, samp_in;
   usrzi_pkg::scale_stage_type  scl_ff, scl_in;
   logic [PB+SB-1:0]            product;

   // Result registers
   logic          rsp_valid_ff;
   logic          rsp_trig_ff;
   logic          rsp_dvalid_ff;
   logic [2:0]    zone_ff, zone_in;
   logic [DB-1:0] last_dist_ff, last_dist_in;
   logic [DB-1:0] dist_sat;

   // Handshake
   logic stall;
   logic accept;
   logic changed;
   logic [VB-1:0] tpu;
   logic [VB-1:0] div_inc;
   logic [VB-1:0] div_next;
   logic [MB-1:0] micro_inc;
   logic [MB-1:0] target;
   logic          timed_done;

   assign stall        = rsp_valid_ff & ~rsp_ch.ready;
   assign req_ch.ready = ~stall;
   assign accept       = req_ch.valid & ~stall;

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff <= usrzi_pkg::TicksPerUsReset;
         trigger_us_ff   <= usrzi_pkg::TriggerUsReset;
         gap_us_ff       <= usrzi_pkg::GapUsReset;
         scale_ff        <= usrzi_pkg::ScaleReset;
         red_max_ff      <= usrzi_pkg::RedMaxReset;
         blue_max_ff     <= usrzi_pkg::BlueMaxReset;
         green_max_ff    <= usrzi_pkg::GreenMaxReset;
      end else if (csr_wr_en) begin
         unique case (usrzi_pkg::csr_index_type'(csr_index))
            usrzi_pkg::CSR_TICKS_PER_US: ticks_per_us_ff <= csr_wr_data[VB-1:0];
            usrzi_pkg::CSR_TRIGGER_US:   trigger_us_ff   <= csr_wr_data[TB-1:0];
            // gap kept in microseconds
            usrzi_pkg::CSR_GAP_MS:
               gap_us_ff <= MB'(csr_wr_data[GB-1:0]) * usrzi_pkg::UsPerMs;
            usrzi_pkg::CSR_SCALE:        scale_ff        <= csr_wr_data[SB-1:0];
            usrzi_pkg::CSR_RED_MAX:      red_max_ff      <= csr_wr_data[DB-1:0];
            usrzi_pkg::CSR_BLUE_MAX:     blue_max_ff     <= csr_wr_data[DB-1:0];
            usrzi_pkg::CSR_GREEN_MAX:    green_max_ff    <= csr_wr_data[DB-1:0];
            default: ;
         endcase
      end
   end

   // Microsecond timer step shared by the timed phases
   assign tpu     = (ticks_per_us_ff == '0) ? VB'(1) : ticks_per_us_ff;
   assign div_inc = tick_div_ff + VB'(1);
   assign target  = (phase_ff == usrzi_pkg::PH_GAP) ? gap_us_ff : MB'(trigger_us_ff);

   always_comb begin
      if (div_inc >= tpu) begin
         div_next  = '0;
         micro_inc = micro_count_ff + MB'(1);
      end else begin
         div_next  = div_inc;
         micro_inc = micro_count_ff;
      end
   end
   assign timed_done = micro_inc >= target;

   assign changed = req_ch.echo_level ^ echo_prev_ff;

   // Phase sequencer
   always_comb begin
      phase_in       = phase_ff;
      tick_div_in    = tick_div_ff;
      micro_count_in = micro_count_ff;
      pulse_ticks_in = pulse_ticks_ff;
      samp_in.vld    = accept;
      samp_in.cap    = 1'b0;
      unique case (phase_ff)
         usrzi_pkg::PH_TRIG_LOW, usrzi_pkg::PH_TRIG_HIGH, usrzi_pkg::PH_GAP: begin
            tick_div_in    = div_next;
            micro_count_in = micro_inc;
            if (timed_done) begin
               tick_div_in    = '0;
               micro_count_in = '0;
               unique case (phase_ff)
                  usrzi_pkg::PH_TRIG_LOW:  phase_in = usrzi_pkg::PH_TRIG_HIGH;
                  usrzi_pkg::PH_TRIG_HIGH: phase_in = usrzi_pkg::PH_WAIT;
                  default:                 phase_in = usrzi_pkg::PH_TRIG_LOW;
               endcase
            end
         end
         usrzi_pkg::PH_WAIT: begin
            if (changed) begin
               pulse_ticks_in = '0;
               phase_in       = usrzi_pkg::PH_COUNT;
               tick_div_in    = '0;
               micro_count_in = '0;
            end
         end
         usrzi_pkg::PH_COUNT: begin
            if (pulse_ticks_ff != usrzi_pkg::PulseMax) begin
               pulse_ticks_in = pulse_ticks_ff + PB'(1);
            end
            if (changed) begin
               samp_in.cap    = 1'b1;
               phase_in       = usrzi_pkg::PH_GAP;
               tick_div_in    = '0;
               micro_count_in = '0;
            end
         end
         default: begin
            // unused code restarts the cycle
            phase_in       = usrzi_pkg::PH_TRIG_LOW;
            tick_div_in    = '0;
            micro_count_in = '0;
         end
      endcase
      samp_in.trig  = (phase_in == usrzi_pkg::PH_TRIG_HIGH);
      samp_in.ticks = pulse_ticks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= usrzi_pkg::PH_TRIG_LOW;
         tick_div_ff    <= '0;
         micro_count_ff <= '0;
         pulse_ticks_ff <= '0;
         echo_prev_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         tick_div_ff    <= tick_div_in;
         micro_count_ff <= micro_count_in;
         pulse_ticks_ff <= pulse_ticks_in;
         echo_prev_ff   <= req_ch.echo_level;
      end
   end

   // Scaling multiply: width times Q0.32 scale, keep the integer part
   assign product         = PB'(samp_ff.ticks) * (PB + SB)'(scale_ff);
   assign scl_in.vld      = samp_ff.vld;
   assign scl_in.trig     = samp_ff.trig;
   assign scl_in.cap      = samp_ff.cap;
   assign scl_in.dist_raw = product[PB+SB-1:SB];

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_ff.vld <= 1'b0;
         scl_ff.vld  <= 1'b0;
      end else if (!stall) begin
         samp_ff.vld      <= samp_in.vld;
         scl_ff.vld       <= scl_in.vld;
         samp_ff.trig     <= samp_in.trig;
         samp_ff.cap      <= samp_in.cap;
         samp_ff.ticks    <= samp_in.ticks;
         scl_ff.trig      <= scl_in.trig;
         scl_ff.cap       <= scl_in.cap;
         scl_ff.dist_raw  <= scl_in.dist_raw;
      end
   end

   // Saturate and pick the zone
   assign dist_sat = (scl_ff.dist_raw > PB'(usrzi_pkg::DistMax)) ? usrzi_pkg::DistMax
                                                                  : scl_ff.dist_raw[DB-1:0];

   always_comb begin
      last_dist_in = last_dist_ff;
      zone_in      = zone_ff;
      if (scl_ff.vld && scl_ff.cap) begin
         last_dist_in = dist_sat;
         priority if (dist_sat <= red_max_ff)   zone_in = 3'b001;
         else if     (dist_sat <= blue_max_ff)  zone_in = 3'b010;
         else if     (dist_sat <= green_max_ff) zone_in = 3'b100;
         else                                   zone_in = 3'b000;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rsp_dvalid_ff <= 1'b0;
         rsp_trig_ff   <= 1'b0;
         zone_ff       <= '0;
         last_dist_ff  <= '0;
      end else if (!stall) begin
         rsp_valid_ff  <= scl_ff.vld;
         rsp_dvalid_ff <= scl_ff.vld & scl_ff.cap;
         rsp_trig_ff   <= scl_ff.trig;
         zone_ff       <= zone_in;
         last_dist_ff  <= last_dist_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.trigger_out    = rsp_trig_ff;
   assign rsp_ch.red_on         = zone_ff[0];
   assign rsp_ch.blue_on        = zone_ff[1];
   assign rsp_ch.green_on       = zone_ff[2];
   assign rsp_ch.distance       = last_dist_ff;
   assign rsp_ch.distance_valid = rsp_dvalid_ff;

   // At most one zone indicator lit
   a_zone_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(zone_ff))
      else $error("more than one zone indicator lit");

   // A fresh distance always lands in the gap phase, never with trigger high
   a_dvalid_no_trig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dvalid_ff |-> !rsp_trig_ff)
      else $error("distance produced with trigger high");

   // Echo phases leave the microsecond timer cleared
   a_echo_timer_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == usrzi_pkg::PH_WAIT || phase_ff == usrzi_pkg::PH_COUNT)
      |-> (micro_count_ff == '0 && tick_div_ff == '0))
      else $error("timer running during echo phases");

   // Distance only moves on a captured echo beat
   a_dist_on_capture: assert property (@(posedge clock) disable iff (reset)
      !$stable(last_dist_ff) |-> $past(scl_ff.vld && scl_ff.cap && !stall))
      else $error("distance changed without a capture");

endmodule

[dv/tb.sv]
// Self-checking testbench of the ultrasonic ranger zone indicator: echo beats in, one reading out per beat.
module tb;

   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 4;      // quiet cycles before a register write
   localparam int TAIL_CYCLES     = 12;
   localparam int RANDOM_SEGMENTS = 12;
   localparam int SEGMENT_BEATS   = 95;
   localparam int FINAL_BEATS     = 150;
   localparam int HOLD_AFTER      = 300;    // readings seen before the long receiver hold
   localparam int LONG_HOLD       = 80;
   localparam longint RUN_LIMIT   = 64'd20_000_000;

   typedef enum logic {OP_BEAT, OP_WRITE} plan_op_type;

   typedef struct packed {
      plan_op_type                         op;
      logic                                echo;
      usrzi_pkg::csr_index_type            idx;
      logic [usrzi_pkg::CsrDataBits-1:0]   data;
   } plan_item_type;

   typedef struct packed {
      logic                           trig;
      logic                           red;
      logic                           blue;
      logic                           green;
      logic [usrzi_pkg::DistBits-1:0] inches;
      logic                           fresh;
   } ranger_out_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   usrzi_pkg::csr_index_type csr_index;
   logic [usrzi_pkg::CsrDataBits-1:0] csr_wr_data;

   usrzi_req_if req_ch ();
   usrzi_rsp_if rsp_ch ();

   ultrasonic_ranger_zone_indicator dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   plan_item_type  echo_plan[$];
   ranger_out_type expected_readings[$];

   // Run statistics and sync flags
   int   beats_planned = 0;
   int   beats_in = 0;
   int   readings_out = 0;
   int   new_distances = 0;
   int   writes_done = 0;
   int   mismatches = 0;
   logic calm = 1'b0;
   logic plan_level = 1'b0;
   int   hold_left = 0;

   // Predictor copy of the configuration
   logic [usrzi_pkg::DivBits-1:0]   cfg_tpu;
   logic [usrzi_pkg::TrigBits-1:0]  cfg_trig_us;
   logic [usrzi_pkg::MicroBits-1:0] cfg_gap_us;
   logic [usrzi_pkg::ScaleBits-1:0] cfg_scale;
   logic [usrzi_pkg::DistBits-1:0]  cfg_red, cfg_blue, cfg_green;

   // Predictor copy of the measurement state
   usrzi_pkg::phase_type            rng_phase;
   logic [usrzi_pkg::DivBits-1:0]   rng_div;
   logic [usrzi_pkg::MicroBits-1:0] rng_usec;
   logic [usrzi_pkg::PulseBits-1:0] rng_width;
   logic                            rng_echo_prev;
   logic                            rng_red, rng_blue, rng_green;
   logic [usrzi_pkg::DistBits-1:0]  rng_dist;

   function automatic void reset_ranger();
      cfg_tpu       = usrzi_pkg::TicksPerUsReset;
      cfg_trig_us   = usrzi_pkg::TriggerUsReset;
      cfg_gap_us    = usrzi_pkg::GapUsReset;
      cfg_scale     = usrzi_pkg::ScaleReset;
      cfg_red       = usrzi_pkg::RedMaxReset;
      cfg_blue      = usrzi_pkg::BlueMaxReset;
      cfg_green     = usrzi_pkg::GreenMaxReset;
      rng_phase     = usrzi_pkg::PH_TRIG_LOW;
      rng_div       = '0;
      rng_usec      = '0;
      rng_width     = '0;
      rng_echo_prev = 1'b0;
      rng_red       = 1'b0;
      rng_blue      = 1'b0;
      rng_green     = 1'b0;
      rng_dist      = '0;
   endfunction

   function automatic void apply_write(input usrzi_pkg::csr_index_type idx,
                                       input logic [usrzi_pkg::CsrDataBits-1:0] v);
      case (idx)
         usrzi_pkg::CSR_TICKS_PER_US: cfg_tpu     = v[usrzi_pkg::DivBits-1:0];
         usrzi_pkg::CSR_TRIGGER_US:   cfg_trig_us = v[usrzi_pkg::TrigBits-1:0];
         usrzi_pkg::CSR_GAP_MS:
            cfg_gap_us = usrzi_pkg::MicroBits'(v[usrzi_pkg::GapBits-1:0]) * usrzi_pkg::UsPerMs;
         usrzi_pkg::CSR_SCALE:        cfg_scale   = v[usrzi_pkg::ScaleBits-1:0];
         usrzi_pkg::CSR_RED_MAX:      cfg_red     = v[usrzi_pkg::DistBits-1:0];
         usrzi_pkg::CSR_BLUE_MAX:     cfg_blue    = v[usrzi_pkg::DistBits-1:0];
         usrzi_pkg::CSR_GREEN_MAX:    cfg_green   = v[usrzi_pkg::DistBits-1:0];
         default: ;
      endcase
   endfunction

   // One tick of the microsecond timer; a zero tick count acts as one
   function automatic logic usec_reached(input logic [usrzi_pkg::MicroBits-1:0] target);
      logic [usrzi_pkg::DivBits-1:0] tpu;
      tpu = (cfg_tpu == '0) ? usrzi_pkg::DivBits'(1) : cfg_tpu;
      rng_div = rng_div + 1'b1;
      if (rng_div >= tpu) begin
         rng_div  = '0;
         rng_usec = rng_usec + 1'b1;
      end
      return rng_usec >= target;
   endfunction

   function automatic void enter_phase(input usrzi_pkg::phase_type nxt);
      rng_phase = nxt;
      rng_div   = '0;
      rng_usec  = '0;
   endfunction

   // Advance the ranger by one echo sample and return the reading after that tick
   function automatic ranger_out_type step_ranger(input logic echo);
      logic           changed;
      logic [63:0]    prod;
      ranger_out_type r;
      changed = echo != rng_echo_prev;
      r.fresh = 1'b0;
      case (rng_phase)
         usrzi_pkg::PH_TRIG_LOW:
            if (usec_reached(usrzi_pkg::MicroBits'(cfg_trig_us)))
               enter_phase(usrzi_pkg::PH_TRIG_HIGH);
         usrzi_pkg::PH_TRIG_HIGH:
            if (usec_reached(usrzi_pkg::MicroBits'(cfg_trig_us)))
               enter_phase(usrzi_pkg::PH_WAIT);
         usrzi_pkg::PH_WAIT:
            if (changed) begin
               rng_width = '0;
               enter_phase(usrzi_pkg::PH_COUNT);
            end
         usrzi_pkg::PH_COUNT: begin
            if (rng_width != usrzi_pkg::PulseMax) rng_width = rng_width + 1'b1;
            if (changed) begin
               prod      = 64'(rng_width) * 64'(cfg_scale);
               rng_dist  = (prod[63:32] > 32'(usrzi_pkg::DistMax)) ? usrzi_pkg::DistMax
                                                                   : prod[32 +: usrzi_pkg::DistBits];
               rng_red   = rng_dist <= cfg_red;
               rng_blue  = !rng_red && (rng_dist <= cfg_blue);
               rng_green = !rng_red && !rng_blue && (rng_dist <= cfg_green);
               r.fresh   = 1'b1;
               enter_phase(usrzi_pkg::PH_GAP);
            end
         end
         usrzi_pkg::PH_GAP:
            if (usec_reached(cfg_gap_us)) enter_phase(usrzi_pkg::PH_TRIG_LOW);
         default:
            enter_phase(usrzi_pkg::PH_TRIG_LOW);
      endcase
      rng_echo_prev = echo;
      r.trig   = rng_phase == usrzi_pkg::PH_TRIG_HIGH;
      r.red    = rng_red;
      r.blue   = rng_blue;
      r.green  = rng_green;
      r.inches = rng_dist;
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Plan building
   task automatic plan_hold(input logic lvl, input int count);
      plan_item_type it;
      it.op   = OP_BEAT;
      it.echo = lvl;
      it.idx  = usrzi_pkg::CSR_TICKS_PER_US;
      it.data = '0;
      repeat (count) echo_plan.push_back(it);
      beats_planned += count;
      plan_level = lvl;
   endtask

   task automatic plan_write(input usrzi_pkg::csr_index_type idx,
                             input logic [usrzi_pkg::CsrDataBits-1:0] val);
      plan_item_type it;
      it.op   = OP_WRITE;
      it.echo = 1'b0;
      it.idx  = idx;
      it.data = val;
      echo_plan.push_back(it);
   endtask

   // One echo pulse of the given width, then enough quiet beats to get back to the wait phase
   task automatic plan_pulse(input int width);
      plan_hold(~plan_level, width);
      plan_hold(~plan_level, 4);
   endtask

   task automatic wait_drained();
      while (beats_in != beats_planned || expected_readings.size() != 0 || echo_plan.size() != 0)
         @(posedge clock);
   endtask

   // Called once drained and with short timing: steers the block into the wait phase
   task automatic plan_to_wait();
      if (rng_phase == usrzi_pkg::PH_COUNT) plan_hold(~plan_level, 4);
      else plan_hold(plan_level, 4);
   endtask

   // Runs of random length: short pulses, single-beat glitches and long missing-echo stretches
   task automatic plan_echo_runs(input int count);
      int run;
      while (count > 0) begin
         case ($urandom_range(0, 9))
            0:       run = 1;
            1, 2:    run = $urandom_range(40, 160);
            default: run = $urandom_range(2, 40);
         endcase
         if (run > count) run = count;
         plan_hold(~plan_level, run);
         count -= run;
      end
   endtask

   task automatic plan_random_setting();
      logic [usrzi_pkg::DistBits-1:0] lo, mid;
      if ($urandom_range(0, 7) == 0) begin
         plan_write(usrzi_pkg::CSR_TICKS_PER_US, $urandom_range(5, 16));
         plan_write(usrzi_pkg::CSR_TRIGGER_US, $urandom_range(0, 2));
      end else begin
         plan_write(usrzi_pkg::CSR_TICKS_PER_US, $urandom_range(0, 4));
         plan_write(usrzi_pkg::CSR_TRIGGER_US, $urandom_range(0, 8));
      end
      plan_write(usrzi_pkg::CSR_GAP_MS, '0);
      case ($urandom_range(0, 3))
         0:       plan_write(usrzi_pkg::CSR_SCALE, $urandom);
         1:       plan_write(usrzi_pkg::CSR_SCALE, '1);
         2:       plan_write(usrzi_pkg::CSR_SCALE, 32'd1 << $urandom_range(24, 31));
         default: plan_write(usrzi_pkg::CSR_SCALE, $urandom_range(0, 1 << 26));
      endcase
      if ($urandom_range(0, 4) == 0) begin
         plan_write(usrzi_pkg::CSR_RED_MAX, $urandom_range(0, 65535));
         plan_write(usrzi_pkg::CSR_BLUE_MAX, $urandom_range(0, 65535));
         plan_write(usrzi_pkg::CSR_GREEN_MAX, $urandom_range(0, 65535));
      end else begin
         lo  = usrzi_pkg::DistBits'($urandom_range(0, 12));
         mid = lo + usrzi_pkg::DistBits'($urandom_range(0, 12));
         plan_write(usrzi_pkg::CSR_RED_MAX, usrzi_pkg::CsrDataBits'(lo));
         plan_write(usrzi_pkg::CSR_BLUE_MAX, usrzi_pkg::CsrDataBits'(mid));
         plan_write(usrzi_pkg::CSR_GREEN_MAX,
                    usrzi_pkg::CsrDataBits'(mid) + $urandom_range(0, 40));
      end
   endtask

   // Clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Driver: request beats and register writes, taken in order from the plan
   int   send_gap = 0;
   int   quiet_cycles = 0;
   int   send_cycles = 0;
   logic send_idle_on = 1'b1;

   always @(posedge clock) begin : driver
      logic                              nxt_valid;
      logic                              nxt_echo;
      logic                              nxt_wen;
      usrzi_pkg::csr_index_type          nxt_idx;
      logic [usrzi_pkg::CsrDataBits-1:0] nxt_data;
      plan_item_type                     head;
      nxt_valid = req_ch.valid;
      nxt_echo  = req_ch.echo_level;
      nxt_wen   = 1'b0;
      nxt_idx   = csr_index;
      nxt_data  = csr_wr_data;
      if (reset) begin
         reset_ranger();
         nxt_valid = 1'b0;
         send_gap  = 0;
         quiet_cycles = 0;
      end else begin
         send_cycles++;
         if (send_cycles % 256 == 0) send_idle_on = $urandom_range(0, 2) != 0;
         // accepted beat: predict its reading
         if (req_ch.valid && req_ch.ready) begin
            expected_readings.push_back(step_ranger(req_ch.echo_level));
            beats_in++;
            nxt_valid = 1'b0;
         end
         if (expected_readings.size() == 0 && !nxt_valid) begin
            if (quiet_cycles < SETTLE_CYCLES) quiet_cycles++;
         end else begin
            quiet_cycles = 0;
         end
         if (!nxt_valid) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (echo_plan.size() != 0) begin
               head = echo_plan[0];
               if (head.op == OP_BEAT) begin
                  nxt_valid = 1'b1;
                  nxt_echo  = head.echo;
                  void'(echo_plan.pop_front());
                  if (!calm && hold_left == 0 && send_idle_on && $urandom_range(0, 5) == 0)
                     send_gap = $urandom_range(1, 12);
               end else if (quiet_cycles >= SETTLE_CYCLES) begin
                  // registers change only with nothing in flight
                  nxt_wen  = 1'b1;
                  nxt_idx  = head.idx;
                  nxt_data = head.data;
                  apply_write(head.idx, head.data);
                  writes_done++;
                  void'(echo_plan.pop_front());
               end
            end
         end
      end
      req_ch.valid      <= nxt_valid;
      req_ch.echo_level <= nxt_echo;
      csr_wr_en         <= nxt_wen;
      csr_index         <= nxt_idx;
      csr_wr_data       <= nxt_data;
   end

   // Monitor: compare each response beat with the oldest predicted reading
   int   rsp_stall = 0;
   int   rsp_cycles = 0;
   logic hold_done = 1'b0;
   logic rsp_idle_on = 1'b1;

   always @(posedge clock) begin : monitor
      logic           nxt_ready;
      ranger_out_type want;
      nxt_ready = 1'b0;
      if (!reset) begin
         rsp_cycles++;
         if (rsp_cycles % 200 == 0) rsp_idle_on = $urandom_range(0, 2) != 0;
         if (rsp_ch.valid && rsp_ch.ready) begin
            readings_out++;
            if (expected_readings.size() == 0) begin
               $error("response beat with no reading expected");
               mismatches++;
            end else begin
               want = expected_readings.pop_front();
               check_field("trigger_out", want.trig, rsp_ch.trigger_out);
               check_field("red_on", want.red, rsp_ch.red_on);
               check_field("blue_on", want.blue, rsp_ch.blue_on);
               check_field("green_on", want.green, rsp_ch.green_on);
               check_field("distance", want.inches, rsp_ch.distance);
               check_field("distance_valid", want.fresh, rsp_ch.distance_valid);
               if (want.fresh) new_distances++;
            end
         end
         // ready: random stall bursts and one long hold
         if (hold_left != 0) begin
            hold_left--;
         end else if (!hold_done && readings_out >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
         end else if (rsp_stall != 0) begin
            rsp_stall--;
         end else if (!calm && rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall = $urandom_range(0, 11);
         end else begin
            nxt_ready = 1'b1;
         end
      end
      rsp_ch.ready <= nxt_ready;
   end

   // Stimulus plan and end of run
   initial begin : stimulus
      int seg;
      int w;
      req_ch.valid      = 1'b0;
      req_ch.echo_level = 1'b0;
      rsp_ch.ready      = 1'b0;
      csr_wr_en         = 1'b0;
      csr_index         = usrzi_pkg::CSR_TICKS_PER_US;
      csr_wr_data       = '0;
      reset             = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // echo edges during the trigger phase are ignored
      plan_hold(1'b1, 1);
      plan_hold(1'b0, 1);
      plan_hold(1'b1, 1);
      plan_hold(1'b0, 1);
      wait_drained();

      // zero tick count and zero targets: one-tick phases, cut short mid-phase
      plan_write(usrzi_pkg::CSR_TICKS_PER_US, '0);
      plan_write(usrzi_pkg::CSR_TRIGGER_US, '0);
      plan_write(usrzi_pkg::CSR_GAP_MS, '0);
      plan_write(usrzi_pkg::CSR_SCALE, '1);
      plan_write(usrzi_pkg::CSR_RED_MAX, '0);
      plan_write(usrzi_pkg::CSR_BLUE_MAX, 1);
      plan_write(usrzi_pkg::CSR_GREEN_MAX, 2);
      plan_to_wait();
      // widths 1..4 land in red, blue, green, then none
      for (w = 1; w <= 4; w++) plan_pulse(w);
      wait_drained();

      // top of every register, zero scale, then a long gap cut short
      plan_write(usrzi_pkg::CSR_TICKS_PER_US, usrzi_pkg::CsrDataBits'(usrzi_pkg::DistMax));
      plan_write(usrzi_pkg::CSR_TRIGGER_US, '1);
      plan_write(usrzi_pkg::CSR_GAP_MS, '1);
      plan_write(usrzi_pkg::CSR_SCALE, '0);
      plan_write(usrzi_pkg::CSR_RED_MAX, usrzi_pkg::CsrDataBits'(usrzi_pkg::DistMax));
      plan_write(usrzi_pkg::CSR_BLUE_MAX, usrzi_pkg::CsrDataBits'(usrzi_pkg::DistMax));
      plan_write(usrzi_pkg::CSR_GREEN_MAX, usrzi_pkg::CsrDataBits'(usrzi_pkg::DistMax));
      plan_pulse(5);
      plan_echo_runs(300);
      plan_write(usrzi_pkg::CSR_GAP_MS, '0);

      for (seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         if (seg == RANDOM_SEGMENTS / 2) wait_drained();
         plan_random_setting();
         plan_echo_runs(SEGMENT_BEATS);
      end

      // closing stretch with both sides streaming
      wait_drained();
      calm = 1'b1;
      plan_random_setting();
      plan_echo_runs(FINAL_BEATS);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d echo beats, %0d readings, %0d new distances, %0d register writes",
               beats_in, readings_out, new_distances, writes_done);
      if (mismatches == 0) begin
         $display("ultrasonic_ranger_zone_indicator verification clean");
      end else begin
         $display("ultrasonic_ranger_zone_indicator verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT);
      $display("ultrasonic_ranger_zone_indicator verification failed");
      $finish;
   end

endmodule
